// ===== hw/rtl/itrr_pkg.sv =====
// ----------------------------------------------------------------------------
// ISO-TP request reassembler package
// Shared constants, codes and the result word type.
// ----------------------------------------------------------------------------
package itrr_pkg;

   // Default buffer size in bytes.
   localparam int BUFFER_BYTES_DEF = 256;

   // Configuration register indexes and reset values.
   localparam logic CSR_SESSION_TIMEOUT    = 1'b0;
   localparam logic CSR_MULTIFRAME_TIMEOUT = 1'b1;
   localparam logic [15:0] SESSION_TIMEOUT_RST    = 16'd5000;
   localparam logic [15:0] MULTIFRAME_TIMEOUT_RST = 16'd5000;

   // Input operations.
   localparam logic [1:0] OP_FRAME = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Frame types, taken from the high nibble of byte 0.
   localparam logic [3:0] FT_SINGLE      = 4'h0;
   localparam logic [3:0] FT_FIRST       = 4'h1;
   localparam logic [3:0] FT_CONSECUTIVE = 4'h2;

   // Result kinds.
   localparam logic [2:0] KIND_CTS     = 3'd0;
   localparam logic [2:0] KIND_NEG     = 3'd1;
   localparam logic [2:0] KIND_READY   = 3'd2;
   localparam logic [2:0] KIND_DATA    = 3'd3;
   localparam logic [2:0] KIND_REFUSED = 3'd4;
   localparam logic [2:0] KIND_BUSY    = 3'd5;

   // Negative response codes.
   localparam logic [7:0] NRC_NONE = 8'h00;
   localparam logic [7:0] NRC_SEQ  = 8'h24;
   localparam logic [7:0] NRC_LONG = 8'h14;

   // Session defaults.
   localparam logic [7:0] SVC_SESSION_CTRL = 8'h10;
   localparam logic [7:0] SUB_DEFAULT      = 8'h01;

   // Payload bytes carried by a first and a consecutive frame.
   localparam logic [11:0] FF_BYTES  = 12'd6;
   localparam logic [11:0] CF_BYTES  = 12'd7;
   localparam logic [11:0] MIN_MULTI = 12'd8;

   // Result queue depth.
   localparam int RSP_DEPTH = 8;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] nrc;
      logic [7:0] service_id;
      logic [7:0] subfunction;
      logic [8:0] length;
      logic       multi;
      logic [7:0] data;
      logic       last;
   } rsp_type;

endpackage

// ===== hw/rtl/itrr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module itrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/isotp_request_reassembler.sv =====
// ----------------------------------------------------------------------------
// ISO-TP request reassembler
// Receive side of a diagnostic server: reassembles single, first and
// consecutive frames, runs session and multi-frame timeouts, serves buffer reads.
// ----------------------------------------------------------------------------
// A word's results are registered in stage one and then written to the result queue;
// a second result enters the queue together with the first and is shown once the first is popped.
// Throughput: one word per cycle while the queue and stage one hold at most six
// results. The buffer is 8 byte-wide banks so a frame's bytes are all written in the same cycle.
// Reset clears all control state; buffer contents are undefined until written.
module isotp_request_reassembler #(
   parameter int BUFFER_BYTES = itrr_pkg::BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_byte0,
   input  logic [7:0]  req_byte1,
   input  logic [7:0]  req_byte2,
   input  logic [7:0]  req_byte3,
   input  logic [7:0]  req_byte4,
   input  logic [7:0]  req_byte5,
   input  logic [7:0]  req_byte6,
   input  logic [7:0]  req_byte7,
   input  logic        req_server_busy,
   input  logic [7:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_nrc,
   output logic [7:0]  rsp_service_id,
   output logic [7:0]  rsp_subfunction,
   output logic [8:0]  rsp_length,
   output logic        rsp_multi,
   output logic [7:0]  rsp_data,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int BANK_DEPTH = (BUFFER_BYTES + 7) / 8;
   localparam int BANK_AW = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;
   localparam logic [11:0] BUF_LEN = BUFFER_BYTES[11:0];
   localparam int QAW = $clog2(itrr_pkg::RSP_DEPTH);
   localparam logic [QAW:0] Q_LIMIT = (QAW + 1)'(itrr_pkg::RSP_DEPTH - 2);

   // Build one result word from the values after the state change.
   function automatic itrr_pkg::rsp_type mk(input logic [2:0] k, input logic [7:0] n,
                                            input logic [7:0] s, input logic [7:0] f,
                                            input logic [11:0] l, input logic m);
      itrr_pkg::rsp_type r;
      r.kind = k;
      r.nrc = n;
      r.service_id = s;
      r.subfunction = f;
      r.length = l[8:0];
      r.multi = m;
      r.data = 8'h00;
      r.last = 1'b0;
      return r;
   endfunction

   // Configuration and control state.
   logic [15:0] sess_to_ff, mft_to_ff;
   logic [31:0] tick_ff, tick_in, act_ff, act_in, gap_start_ff, gap_start_in;
   logic [7:0]  svc_ff, svc_in, sub_ff, sub_in;
   logic [11:0] total_ff, total_in, recv_ff, recv_in;
   logic [3:0]  seq_ff, seq_in;
   logic        rcv_ff, rcv_in, gap_on_ff, gap_on_in;

   // Stage one and the result queue.
   logic [1:0]          s1_cnt_ff, s1_cnt_in;
   itrr_pkg::rsp_type   s1_r0_ff, s1_r0_in, s1_r1_ff, s1_r1_in, push0, push1;
   logic                s1_rd_ff, s1_rd_in;
   logic [2:0]          s1_bank_ff;
   itrr_pkg::rsp_type   q_ff [itrr_pkg::RSP_DEPTH];
   logic [QAW-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [QAW:0]        qcnt_ff, qcnt_in;

   // Buffer bank ports.
   logic                wen [8];
   logic [BANK_AW-1:0]  waddr [8];
   logic [7:0]          wdata [8];
   logic [7:0]          rdata [8];
   logic [BANK_AW-1:0]  raddr;

   logic        accept, pop;
   logic [7:0]  fb [8];
   logic [11:0] ff_total, remaining, cf_cnt, pos, new_recv;
   logic [2:0]  off;
   logic [31:0] tick_next;
   itrr_pkg::rsp_type rb;

   assign accept = req_valid && !req_stall;
   assign pop = rsp_valid && !rsp_stall;
   assign req_stall = (qcnt_ff + (QAW + 1)'(s1_cnt_ff)) > Q_LIMIT;

   assign fb[0] = req_byte0;
   assign fb[1] = req_byte1;
   assign fb[2] = req_byte2;
   assign fb[3] = req_byte3;
   assign fb[4] = req_byte4;
   assign fb[5] = req_byte5;
   assign fb[6] = req_byte6;
   assign fb[7] = req_byte7;

   assign ff_total = {req_byte0[3:0], req_byte1};
   assign remaining = (total_ff > recv_ff) ? (total_ff - recv_ff) : 12'd0;
   assign cf_cnt = (remaining >= itrr_pkg::CF_BYTES) ? itrr_pkg::CF_BYTES : remaining;
   assign new_recv = recv_ff + cf_cnt;
   assign tick_next = tick_ff + 32'd1;
   assign raddr = BANK_AW'({4'b0, req_read_index} >> 3);

   // Decode one word: next state, bank writes and up to two results.
   always_comb begin
      tick_in = tick_ff;
      act_in = act_ff;
      gap_start_in = gap_start_ff;
      svc_in = svc_ff;
      sub_in = sub_ff;
      total_in = total_ff;
      recv_in = recv_ff;
      seq_in = seq_ff;
      rcv_in = rcv_ff;
      gap_on_in = gap_on_ff;
      s1_cnt_in = 2'd0;
      s1_r0_in = '0;
      s1_r1_in = '0;
      s1_rd_in = 1'b0;
      rb = '0;
      pos = 12'd0;
      off = 3'd0;
      for (int k = 0; k < 8; k++) begin
         wen[k] = 1'b0;
         waddr[k] = '0;
         wdata[k] = 8'h00;
      end
      if (accept) begin
         case (req_op)
            itrr_pkg::OP_FRAME: begin
               case (req_byte0[7:4])
                  itrr_pkg::FT_SINGLE: begin
                     if (req_byte0[3:0] != 4'd0 && req_byte0[3:0] <= 4'd7) begin
                        s1_cnt_in = 2'd1;
                        if (req_server_busy) begin
                           s1_r0_in = mk(itrr_pkg::KIND_BUSY, itrr_pkg::NRC_NONE,
                                         svc_ff, sub_ff, recv_ff, 1'b0);
                        end else begin
                           act_in = tick_ff;
                           svc_in = req_byte1;
                           sub_in = req_byte2;
                           s1_r0_in = mk(itrr_pkg::KIND_READY, itrr_pkg::NRC_NONE,
                                         req_byte1, req_byte2, recv_ff, 1'b0);
                        end
                     end
                  end
                  itrr_pkg::FT_FIRST: begin
                     if (ff_total >= itrr_pkg::MIN_MULTI) begin
                        // A running transfer is dropped first.
                        if (rcv_ff) begin
                           total_in = 12'd0;
                           recv_in = 12'd0;
                           seq_in = 4'd0;
                           rcv_in = 1'b0;
                           gap_on_in = 1'b0;
                        end
                        if (req_server_busy) begin
                           rb = mk(itrr_pkg::KIND_BUSY, itrr_pkg::NRC_NONE,
                                   svc_ff, sub_ff, recv_in, 1'b0);
                        end else if (ff_total > BUF_LEN) begin
                           act_in = tick_ff;
                           total_in = 12'd0;
                           recv_in = 12'd0;
                           seq_in = 4'd0;
                           rcv_in = 1'b0;
                           gap_on_in = 1'b0;
                           rb = mk(itrr_pkg::KIND_NEG, itrr_pkg::NRC_LONG,
                                   svc_ff, sub_ff, 12'd0, 1'b0);
                        end else begin
                           act_in = tick_ff;
                           total_in = ff_total;
                           recv_in = itrr_pkg::FF_BYTES;
                           seq_in = 4'd1;
                           rcv_in = 1'b1;
                           gap_on_in = 1'b1;
                           gap_start_in = tick_ff;
                           svc_in = req_byte2;
                           for (int k = 0; k < 6; k++) begin
                              wen[k] = 1'b1;
                              waddr[k] = '0;
                              wdata[k] = fb[k + 2];
                           end
                           rb = mk(itrr_pkg::KIND_CTS, itrr_pkg::NRC_NONE,
                                   req_byte2, sub_ff, itrr_pkg::FF_BYTES, 1'b0);
                        end
                        if (rcv_ff) begin
                           s1_cnt_in = 2'd2;
                           s1_r0_in = mk(itrr_pkg::KIND_NEG, itrr_pkg::NRC_SEQ,
                                         svc_ff, sub_ff, 12'd0, 1'b0);
                           s1_r1_in = rb;
                        end else begin
                           s1_cnt_in = 2'd1;
                           s1_r0_in = rb;
                        end
                     end
                  end
                  itrr_pkg::FT_CONSECUTIVE: begin
                     if (rcv_ff) begin
                        act_in = tick_ff;
                        if (req_byte0[3:0] != seq_ff) begin
                           total_in = 12'd0;
                           recv_in = 12'd0;
                           seq_in = 4'd0;
                           rcv_in = 1'b0;
                           gap_on_in = 1'b0;
                           s1_cnt_in = 2'd1;
                           s1_r0_in = mk(itrr_pkg::KIND_NEG, itrr_pkg::NRC_SEQ,
                                         svc_ff, sub_ff, 12'd0, 1'b0);
                        end else begin
                           // Each bank takes at most one of the appended bytes.
                           for (int k = 0; k < 8; k++) begin
                              off = 3'(3'(k) - recv_ff[2:0]);
                              pos = recv_ff + 12'(off);
                              if (12'(off) < cf_cnt && pos < BUF_LEN) begin
                                 wen[k] = 1'b1;
                                 waddr[k] = BANK_AW'(pos >> 3);
                                 wdata[k] = fb[off + 3'd1];
                              end
                           end
                           recv_in = new_recv;
                           seq_in = req_byte0[3:0] + 4'd1;
                           gap_start_in = tick_ff;
                           if (new_recv >= total_ff) begin
                              rcv_in = 1'b0;
                              gap_on_in = 1'b0;
                              s1_cnt_in = 2'd1;
                              s1_r0_in = mk(itrr_pkg::KIND_READY, itrr_pkg::NRC_NONE,
                                            svc_ff, sub_ff, new_recv, 1'b1);
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            itrr_pkg::OP_TICK: begin
               tick_in = tick_next;
               if ((tick_next - act_ff) >= {16'd0, sess_to_ff}) begin
                  act_in = tick_next;
                  svc_in = itrr_pkg::SVC_SESSION_CTRL;
                  sub_in = itrr_pkg::SUB_DEFAULT;
               end else if (gap_on_ff && (tick_next - gap_start_ff) >= {16'd0, mft_to_ff}) begin
                  total_in = 12'd0;
                  recv_in = 12'd0;
                  seq_in = 4'd0;
                  rcv_in = 1'b0;
                  gap_on_in = 1'b0;
               end
            end
            itrr_pkg::OP_READ: begin
               s1_cnt_in = 2'd1;
               if (recv_ff > 12'd1 && {4'd0, req_read_index} < recv_ff &&
                   {4'd0, req_read_index} < BUF_LEN) begin
                  s1_rd_in = 1'b1;
                  s1_r0_in = mk(itrr_pkg::KIND_DATA, itrr_pkg::NRC_NONE,
                                svc_ff, sub_ff, recv_ff, 1'b0);
               end else begin
                  s1_r0_in = mk(itrr_pkg::KIND_REFUSED, itrr_pkg::NRC_NONE,
                                svc_ff, sub_ff, recv_ff, 1'b0);
               end
            end
            default: begin
            end
         endcase
         s1_r0_in.last = (s1_cnt_in == 2'd1);
         s1_r1_in.last = 1'b1;
      end
   end

   // Byte-interleaved buffer banks.
   for (genvar g = 0; g < 8; g++) begin : g_bank
      itrr_ram #(
         .WIDTH (8),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wen[g]),
         .wr_addr (waddr[g]),
         .wr_data (wdata[g]),
         .rd_addr (raddr),
         .rd_data (rdata[g])
      );
   end

   // Merge the read data into stage one results.
   always_comb begin
      push0 = s1_r0_ff;
      push1 = s1_r1_ff;
      if (s1_rd_ff) begin
         push0.data = rdata[s1_bank_ff];
      end
   end

   // Result queue pointers.
   always_comb begin
      wp_in = wp_ff + QAW'(s1_cnt_ff);
      rp_in = rp_ff + QAW'(pop);
      qcnt_in = qcnt_ff + (QAW + 1)'(s1_cnt_ff) - (QAW + 1)'(pop);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sess_to_ff <= itrr_pkg::SESSION_TIMEOUT_RST;
         mft_to_ff <= itrr_pkg::MULTIFRAME_TIMEOUT_RST;
         tick_ff <= '0;
         act_ff <= '0;
         gap_start_ff <= '0;
         svc_ff <= itrr_pkg::SVC_SESSION_CTRL;
         sub_ff <= itrr_pkg::SUB_DEFAULT;
         total_ff <= '0;
         recv_ff <= '0;
         seq_ff <= '0;
         rcv_ff <= 1'b0;
         gap_on_ff <= 1'b0;
         s1_cnt_ff <= '0;
         s1_rd_ff <= 1'b0;
         wp_ff <= '0;
         rp_ff <= '0;
         qcnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == itrr_pkg::CSR_SESSION_TIMEOUT) begin
               sess_to_ff <= csr_wdata;
            end else begin
               mft_to_ff <= csr_wdata;
            end
         end
         tick_ff <= tick_in;
         act_ff <= act_in;
         gap_start_ff <= gap_start_in;
         svc_ff <= svc_in;
         sub_ff <= sub_in;
         total_ff <= total_in;
         recv_ff <= recv_in;
         seq_ff <= seq_in;
         rcv_ff <= rcv_in;
         gap_on_ff <= gap_on_in;
         s1_cnt_ff <= s1_cnt_in;
         s1_rd_ff <= s1_rd_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         qcnt_ff <= qcnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_r0_ff <= s1_r0_in;
      s1_r1_ff <= s1_r1_in;
      s1_bank_ff <= req_read_index[2:0];
      if (s1_cnt_ff != 2'd0) begin
         q_ff[wp_ff] <= push0;
      end
      if (s1_cnt_ff == 2'd2) begin
         q_ff[QAW'(wp_ff + 1'b1)] <= push1;
      end
   end

   assign rsp_valid = (qcnt_ff != '0);
   assign rsp_kind = q_ff[rp_ff].kind;
   assign rsp_nrc = q_ff[rp_ff].nrc;
   assign rsp_service_id = q_ff[rp_ff].service_id;
   assign rsp_subfunction = q_ff[rp_ff].subfunction;
   assign rsp_length = q_ff[rp_ff].length;
   assign rsp_multi = q_ff[rp_ff].multi;
   assign rsp_data = q_ff[rp_ff].data;
   assign rsp_last = q_ff[rp_ff].last;

   // The gap timer runs exactly while a transfer is open.
   a_gap_tracks_rcv: assert property (@(posedge clock) disable iff (reset)
      gap_on_ff == rcv_ff) else $error("gap timer out of step with transfer");

   // An open transfer never holds more bytes than announced.
   a_recv_bound: assert property (@(posedge clock) disable iff (reset)
      rcv_ff |-> (recv_ff <= total_ff && total_ff >= itrr_pkg::MIN_MULTI))
      else $error("received length beyond total length");

   // The queue never overflows.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (qcnt_ff + (QAW + 1)'(s1_cnt_ff)) <= (QAW + 1)'(itrr_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   // Stage one carries two results only for a first frame.
   a_two_results: assert property (@(posedge clock) disable iff (reset)
      s1_cnt_ff == 2'd2 |-> (s1_r0_ff.kind == itrr_pkg::KIND_NEG && !s1_rd_ff))
      else $error("unexpected double result");

endmodule
